@@ rtl/stfa_pkg.sv @@
// Shared constants, request and status codes, and controller/datapath interface types.
`timescale 1ns / 1ps
`default_nettype none
package stfa_pkg;

	localparam int SLOT_COUNT_DEF = 256;
	localparam int VALUE_BITS_DEF = 32;

	localparam int KIND_W   = 2;
	localparam int SLOT_W   = 8;
	localparam int VALUE_W  = 32;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 9;

	localparam logic [COUNT_W-1:0] CAP_RESET = 9'd256;

	localparam logic [KIND_W-1:0] KIND_GET   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_ERASE = 2'd3;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic clear;    // clearing sweep write
		logic capture;  // latch request, issue memory reads
		logic commit;   // apply writes, load output register
	} ctrl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last; // sweep at final entry
		logic out_free; // output register can take a result
	} dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/stfa_ctrl.sv @@
// Sequencing controller: clearing sweep, request capture and commit.
`timescale 1ns / 1ps
`default_nettype none
module stfa_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   in_valid,
	output logic                  in_stall,
	input  wire stfa_pkg::dp_sts_t sts,
	output stfa_pkg::ctrl_cmd_t   cmd
);

	localparam logic [1:0] S_CLEAR = 2'd0;
	localparam logic [1:0] S_IDLE  = 2'd1;
	localparam logic [1:0] S_EXEC  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d     = state_q;
		cmd.clear   = 1'b0;
		cmd.capture = 1'b0;
		cmd.commit  = 1'b0;
		case (state_q)
			S_CLEAR: begin
				cmd.clear = 1'b1;
				if (sts.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_EXEC;
				end
			end
			S_EXEC: begin
				// hold until the output register has room
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

@@ rtl/stfa_dp.sv @@
// Datapath: slot table, free-slot stack, count, capacity register and result register.
`timescale 1ns / 1ps
`default_nettype none
module stfa_dp #(
	parameter int SLOT_COUNT = stfa_pkg::SLOT_COUNT_DEF,
	parameter int VALUE_BITS = stfa_pkg::VALUE_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire stfa_pkg::ctrl_cmd_t             cmd,
	output stfa_pkg::dp_sts_t                    sts,
	input  wire                                  cfg_wr_en,
	input  wire  [stfa_pkg::COUNT_W-1:0]         cfg_wr_data,
	input  wire  [stfa_pkg::KIND_W-1:0]          kind,
	input  wire  [stfa_pkg::SLOT_W-1:0]          slot,
	input  wire  [stfa_pkg::VALUE_W-1:0]         entry_value,
	input  wire                                  out_stall,
	output logic                                 out_valid,
	output logic [stfa_pkg::SLOT_W-1:0]          result_slot,
	output logic [stfa_pkg::VALUE_W-1:0]         result_value,
	output logic [stfa_pkg::STATUS_W-1:0]        status,
	output logic [stfa_pkg::COUNT_W-1:0]         occupied_count
);

	localparam int SW   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CW   = $clog2(SLOT_COUNT + 1);
	localparam int CMPW = (CW > stfa_pkg::COUNT_W) ? CW : stfa_pkg::COUNT_W;

	logic [VALUE_BITS-1:0] tbl_mem [SLOT_COUNT];
	logic [SW-1:0]         stk_mem [SLOT_COUNT];

	logic [stfa_pkg::COUNT_W-1:0] cap_q;
	logic [CW-1:0]                count_q;
	logic [SW-1:0]                clr_q;

	logic [stfa_pkg::KIND_W-1:0]  kind_q;
	logic [stfa_pkg::SLOT_W-1:0]  slot_q;
	logic [VALUE_BITS-1:0]        val_q;
	logic [VALUE_BITS-1:0]        tbl_rd_q;
	logic [SW-1:0]                stk_rd_q;

	logic                         out_valid_q;
	logic [stfa_pkg::SLOT_W-1:0]  rslot_q;
	logic [stfa_pkg::VALUE_W-1:0] rval_q;
	logic [stfa_pkg::STATUS_W-1:0] status_q;
	logic [stfa_pkg::COUNT_W-1:0] occ_q;

	logic [CMPW-1:0]              cap_eff;
	logic                         in_range;
	logic                         full;
	logic                         is_push;
	logic                         tbl_empty;
	logic                         push_ok;
	logic                         set_ok;
	logic                         erase_ok;
	logic                         stk_dec;
	logic [CW-1:0]                count_d;
	logic [stfa_pkg::STATUS_W-1:0] status_d;
	logic [stfa_pkg::SLOT_W-1:0]  rslot_d;
	logic [stfa_pkg::VALUE_W-1:0] rval_d;
	logic                         tbl_we;
	logic [SW-1:0]                tbl_wa;
	logic [VALUE_BITS-1:0]        tbl_wd;
	logic                         stk_we;
	logic [SW-1:0]                stk_wa;
	logic [SW-1:0]                stk_wd;

	// capacity register, writable at any time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= stfa_pkg::CAP_RESET;
		end else if (cfg_wr_en) begin
			cap_q <= cfg_wr_data;
		end
	end

	assign cap_eff = (CMPW'(cap_q) > CMPW'(SLOT_COUNT)) ? CMPW'(SLOT_COUNT) : CMPW'(cap_q);

	// request decode on captured request and registered read data
	always_comb begin
		in_range  = CMPW'(slot_q) < cap_eff;
		full      = CMPW'(count_q) >= cap_eff;
		is_push   = (kind_q == stfa_pkg::KIND_PUSH);
		tbl_empty = (tbl_rd_q == '0);
		push_ok   = is_push && !full;
		set_ok    = (kind_q == stfa_pkg::KIND_SET) && in_range;
		erase_ok  = (kind_q == stfa_pkg::KIND_ERASE) && in_range && !tbl_empty;
		stk_dec   = erase_ok && (count_q != '0);

		count_d = count_q;
		if (push_ok) begin
			count_d = count_q + CW'(1);
		end else if (stk_dec) begin
			count_d = count_q - CW'(1);
		end

		if (is_push) begin
			status_d = full ? stfa_pkg::ST_FULL : stfa_pkg::ST_OK;
		end else if (!in_range) begin
			status_d = stfa_pkg::ST_RANGE;
		end else if ((kind_q == stfa_pkg::KIND_ERASE) && tbl_empty) begin
			status_d = stfa_pkg::ST_EMPTY;
		end else begin
			status_d = stfa_pkg::ST_OK;
		end

		rslot_d = push_ok ? stfa_pkg::SLOT_W'(stk_rd_q) : slot_q;
		rval_d  = (!is_push && (status_d == stfa_pkg::ST_OK)) ?
			stfa_pkg::VALUE_W'(tbl_rd_q) : '0;
	end

	// one write port per memory
	always_comb begin
		tbl_we = 1'b0;
		tbl_wa = SW'(slot_q);
		tbl_wd = val_q;
		stk_we = 1'b0;
		stk_wa = clr_q;
		stk_wd = clr_q;
		if (cmd.clear) begin
			tbl_we = 1'b1;
			tbl_wa = clr_q;
			tbl_wd = '0;
			stk_we = 1'b1;
		end else if (cmd.commit) begin
			if (push_ok) begin
				tbl_we = 1'b1;
				tbl_wa = stk_rd_q;
			end else if (set_ok) begin
				tbl_we = 1'b1;
			end else if (erase_ok) begin
				tbl_we = 1'b1;
				tbl_wd = '0;
			end
			if (stk_dec) begin
				stk_we = 1'b1;
				stk_wa = SW'(count_q - CW'(1));
				stk_wd = SW'(slot_q);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tbl_we) begin
			tbl_mem[tbl_wa] <= tbl_wd;
		end
		if (cmd.capture) begin
			tbl_rd_q <= tbl_mem[SW'(slot)];
		end
	end

	always_ff @(posedge clk) begin
		if (stk_we) begin
			stk_mem[stk_wa] <= stk_wd;
		end
		if (cmd.capture) begin
			stk_rd_q <= stk_mem[SW'(count_q)];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			slot_q <= slot;
			val_q  <= VALUE_BITS'(entry_value);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			clr_q   <= '0;
		end else begin
			if (cmd.clear) begin
				clr_q <= clr_q + SW'(1);
			end
			if (cmd.commit) begin
				count_q <= count_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rslot_q  <= rslot_d;
			rval_q   <= rval_d;
			status_q <= status_d;
			occ_q    <= stfa_pkg::COUNT_W'(count_d);
		end
	end

	assign sts.clr_last = (clr_q == SW'(SLOT_COUNT - 1));
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid      = out_valid_q;
	assign result_slot    = rslot_q;
	assign result_value   = rval_q;
	assign status         = status_q;
	assign occupied_count = occ_q;

endmodule
`default_nettype wire

@@ rtl/slot_table_free_list_allocator.sv @@
// Top level: slot table with free-slot stack allocator (controller plus datapath).
// A transaction is captured and both memories are read into registers; the writes and the result
// load follow on commit, which waits for the previous result to be taken; in_stall holds the next
// transaction off until then. Reset: arst_n clears control state, then a sweep zeroes the table
// and loads the stack with 0..SLOT_COUNT-1; in_stall stays high during the sweep.
`timescale 1ns / 1ps
`default_nettype none
module slot_table_free_list_allocator #(
	parameter int SLOT_COUNT = stfa_pkg::SLOT_COUNT_DEF,
	parameter int VALUE_BITS = stfa_pkg::VALUE_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	// capacity register write
	input  wire                                  cfg_wr_en,
	input  wire  [stfa_pkg::COUNT_W-1:0]         cfg_wr_data,
	// request channel
	input  wire                                  in_valid,
	output logic                                 in_stall,
	input  wire  [stfa_pkg::KIND_W-1:0]          kind,
	input  wire  [stfa_pkg::SLOT_W-1:0]          slot,
	input  wire  [stfa_pkg::VALUE_W-1:0]         entry_value,
	// result channel
	output logic                                 out_valid,
	input  wire                                  out_stall,
	output logic [stfa_pkg::SLOT_W-1:0]          result_slot,
	output logic [stfa_pkg::VALUE_W-1:0]         result_value,
	output logic [stfa_pkg::STATUS_W-1:0]        status,
	output logic [stfa_pkg::COUNT_W-1:0]         occupied_count
);

	// Controller walks CLEAR -> IDLE -> EXEC -> IDLE. In IDLE a transaction is
	// captured and both memories are read (table at the slot, stack at the
	// count). In EXEC the decision is made on the registered read data and
	// the writes, count update and result load happen in one go, waiting
	// only if the previous result has not been taken.
	stfa_pkg::ctrl_cmd_t cmd;
	stfa_pkg::dp_sts_t   sts;

	stfa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Datapath keeps the memories, count, capacity and the result register.
	// Push pops from stack[count]; erase of a filled slot pushes it back at
	// count-1 (skipped when the count is already zero); set leaves the
	// bookkeeping alone.
	stfa_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.VALUE_BITS (VALUE_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.kind           (kind),
		.slot           (slot),
		.entry_value    (entry_value),
		.out_stall      (out_stall),
		.out_valid      (out_valid),
		.result_slot    (result_slot),
		.result_value   (result_value),
		.status         (status),
		.occupied_count (occupied_count)
	);

endmodule
`default_nettype wire
